@@ sv/tkpc_pkg.sv @@
// Shared constants and types for the touch key press classifier.
package tkpc_pkg;

  localparam int KEY_COUNT    = 9;
  localparam int HISTORY_BITS = 16;
  localparam int MASK_BITS    = 9;
  localparam int STATUS_BITS  = 12;
  localparam int MODE_BITS    = 4;

  typedef logic [HISTORY_BITS-1:0] hist_t;

  localparam hist_t HistOne     = hist_t'(1);
  localparam hist_t LongLevel   = hist_t'(32'h80);
  localparam hist_t RepeatLevel = hist_t'(32'h100);

  // Per-key classification of one scan.
  typedef struct packed {
    logic pressed;
    logic changed;
    logic short_press;
    logic long_release;
    logic long_press;
    logic repeat_hit;
  } key_flags_t;

  // One report beat.
  typedef struct packed {
    logic [MASK_BITS-1:0] pressed_mask;
    logic [MASK_BITS-1:0] short_press_mask;
    logic [MASK_BITS-1:0] long_release_mask;
    logic [MASK_BITS-1:0] long_press_mask;
    logic [MASK_BITS-1:0] repeat_mask;
    logic [MODE_BITS-1:0] report_mode;
  } report_t;

endpackage

@@ sv/tkpc_key_cell.sv @@
// History register and press classification for a single key.
module tkpc_key_cell
  import tkpc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       touch_i,
  output key_flags_t flags_o
);

  hist_t hist_q;
  hist_t hist_d;
  hist_t hist_shift;

  always_comb begin
    hist_shift = {hist_q[HISTORY_BITS-2:0], touch_i};

    flags_o.pressed      = touch_i;
    flags_o.changed      = touch_i ^ hist_q[0];
    flags_o.short_press  = !touch_i && (hist_shift > HistOne) && (hist_shift < LongLevel);
    flags_o.long_release = !touch_i && (hist_shift >= LongLevel);
    flags_o.long_press   = touch_i && (hist_shift > LongLevel);
    flags_o.repeat_hit   = touch_i && (hist_shift > RepeatLevel);

    // A release clears the history.
    hist_d = touch_i ? hist_shift : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else if (step_i) begin
      hist_q <= hist_d;
    end
  end

endmodule

@@ sv/tkpc_out_reg.sv @@
// Output register that holds one report beat until the consumer takes it.
module tkpc_out_reg
  import tkpc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  report_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    stall_i,
  output report_t data_o
);

  logic    valid_q;
  logic    valid_d;
  report_t data_q;

  assign ready_o = !valid_q || !stall_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      data_q <= data_i;
    end
  end

endmodule

@@ sv/touch_key_press_classifier.sv @@
// Touch key press classifier: per-key history, press classification and report output.
//
// Each input beat is one periodic scan of the touch-status bits, bit i being
// key i. The block accepts one scan per clock cycle while its input is not
// stalled. A scan is first captured in an input register; there every key
// classifies it against its own history register in parallel (short press on a
// release after a short hold, long release after a long hold, long press and
// repeat while held past the two thresholds), and when the scan moves on each
// key shifts its touch bit into that register. If any key changed level, or any
// key is in long press, a report beat tagged with the current mode register is
// loaded into the output register as the scan moves on. Scans that cause no
// report are consumed silently. The output register keeps its beat
// while the consumer stalls; a scan that needs the output register then waits
// in the input register, and the input stalls only while such a scan waits.
// The mode register is written by a single write-enable port and should only be
// changed while no scan is in flight.
module touch_key_press_classifier
  import tkpc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_write_en_i,
  input  logic [MODE_BITS-1:0]   cfg_write_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [STATUS_BITS-1:0] touch_status_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [MASK_BITS-1:0]   pressed_mask_o,
  output logic [MASK_BITS-1:0]   short_press_mask_o,
  output logic [MASK_BITS-1:0]   long_release_mask_o,
  output logic [MASK_BITS-1:0]   long_press_mask_o,
  output logic [MASK_BITS-1:0]   repeat_mask_o,
  output logic [MODE_BITS-1:0]   report_mode_o
);

  logic [MODE_BITS-1:0] mode_tag_q;

  logic                 scan_valid_q;
  logic                 scan_valid_d;
  logic [KEY_COUNT-1:0] touch_q;

  logic                 in_accept;
  logic                 step;
  logic                 report;
  logic                 out_ready;

  key_flags_t           flags [KEY_COUNT];
  logic [KEY_COUNT-1:0] changed_vec;
  logic [KEY_COUNT-1:0] long_vec;
  report_t              rep_d;
  report_t              rep_q;

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_tag_q <= '0;
    end else if (cfg_write_en_i) begin
      mode_tag_q <= cfg_write_data_i;
    end
  end

  // Input register. The scan moves on when it makes no report or the output
  // register can take its report.
  assign step       = scan_valid_q && (!report || out_ready);
  assign in_stall_o = scan_valid_q && !step;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    scan_valid_d = scan_valid_q;
    if (step) begin
      scan_valid_d = 1'b0;
    end
    if (in_accept) begin
      scan_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_valid_q <= 1'b0;
    end else begin
      scan_valid_q <= scan_valid_d;
    end
  end

  // Touch bits above the key count are not used.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      touch_q <= touch_status_i[KEY_COUNT-1:0];
    end
  end

  // One classification cell per key, all working on the same scan.
  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
    tkpc_key_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (step),
      .touch_i (touch_q[k]),
      .flags_o (flags[k])
    );
    assign changed_vec[k] = flags[k].changed;
    assign long_vec[k]    = flags[k].long_press;
  end

  assign report = (|changed_vec) || (|long_vec);

  // Keys beyond the mask width still drive the report decision but are
  // dropped from the masks.
  always_comb begin
    rep_d = '0;
    for (int m = 0; m < MASK_BITS; m++) begin
      if (m < KEY_COUNT) begin
        rep_d.pressed_mask[m]      = flags[m].pressed;
        rep_d.short_press_mask[m]  = flags[m].short_press;
        rep_d.long_release_mask[m] = flags[m].long_release;
        rep_d.long_press_mask[m]   = flags[m].long_press;
        rep_d.repeat_mask[m]       = flags[m].repeat_hit;
      end
    end
    rep_d.report_mode = mode_tag_q;
  end

  tkpc_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (scan_valid_q && report),
    .data_i  (rep_d),
    .ready_o (out_ready),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (rep_q)
  );

  assign pressed_mask_o      = rep_q.pressed_mask;
  assign short_press_mask_o  = rep_q.short_press_mask;
  assign long_release_mask_o = rep_q.long_release_mask;
  assign long_press_mask_o   = rep_q.long_press_mask;
  assign repeat_mask_o       = rep_q.repeat_mask;
  assign report_mode_o       = rep_q.report_mode;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the touch key press classifier with its report scoreboard.
module tb_top;
  import tkpc_pkg::*;

  // Scans per random phase; four phases give about two thousand beats in all.
  localparam int PHASE_SCANS = 500;
  // The block holds a scan in its input register and a report in its output
  // register, so a handful of cycles after the last report is plenty for a
  // scan that produced no report to retire.
  localparam int SETTLE_CYCLES = 4;
  // The slowest correct run is roughly 2000 scans under heavy idling and
  // stalling; this limit leaves a wide margin.
  localparam int CYCLE_LIMIT = 300000;

  // The scoreboard tracks the hold history of every key, predicts the report
  // that each accepted scan should produce, and checks reports in order.
  class report_scoreboard;
    hist_t                hold_trace[KEY_COUNT];
    logic [MODE_BITS-1:0] mode_copy;
    report_t              expected_reports[$];
    int                   errors;

    function new();
      foreach (hold_trace[k]) hold_trace[k] = '0;
      mode_copy = '0;
      errors = 0;
    endfunction

    function void set_mode(logic [MODE_BITS-1:0] value);
      mode_copy = value;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    // Shift one scan into every key's history and queue the report it causes.
    function void note_scan(logic [STATUS_BITS-1:0] status);
      report_t rpt;
      hist_t   h;
      logic    report_due;
      rpt = '0;
      report_due = 1'b0;
      for (int k = 0; k < KEY_COUNT; k++) begin
        h = {hold_trace[k][HISTORY_BITS-2:0], status[k]};
        if (h[0] != h[1]) report_due = 1'b1;
        if (h[0] && k < MASK_BITS) rpt.pressed_mask[k] = 1'b1;
        if (!h[0]) begin
          if (h > HistOne && k < MASK_BITS) begin
            if (h < LongLevel) rpt.short_press_mask[k] = 1'b1;
            else rpt.long_release_mask[k] = 1'b1;
          end
          h = '0;
        end
        if (h > LongLevel) begin
          report_due = 1'b1;
          if (k < MASK_BITS) rpt.long_press_mask[k] = 1'b1;
          if (h > RepeatLevel && k < MASK_BITS) rpt.repeat_mask[k] = 1'b1;
        end
        hold_trace[k] = h;
      end
      rpt.report_mode = mode_copy;
      if (report_due) expected_reports.push_back(rpt);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      compare_field("pressed_mask", want.pressed_mask, got.pressed_mask);
      compare_field("short_press_mask", want.short_press_mask, got.short_press_mask);
      compare_field("long_release_mask", want.long_release_mask, got.long_release_mask);
      compare_field("long_press_mask", want.long_press_mask, got.long_press_mask);
      compare_field("repeat_mask", want.repeat_mask, got.repeat_mask);
      compare_field("report_mode", want.report_mode, got.report_mode);
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_write_en_i;
  logic [MODE_BITS-1:0]   cfg_write_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [STATUS_BITS-1:0] touch_status_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [MASK_BITS-1:0]   pressed_mask_o;
  logic [MASK_BITS-1:0]   short_press_mask_o;
  logic [MASK_BITS-1:0]   long_release_mask_o;
  logic [MASK_BITS-1:0]   long_press_mask_o;
  logic [MASK_BITS-1:0]   repeat_mask_o;
  logic [MODE_BITS-1:0]   report_mode_o;

  report_scoreboard     board;
  int                   stall_pct;
  int                   cycle_count;
  logic [KEY_COUNT-1:0] held_keys;

  touch_key_press_classifier u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_write_en_i      (cfg_write_en_i),
    .cfg_write_data_i    (cfg_write_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .touch_status_i      (touch_status_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .pressed_mask_o      (pressed_mask_o),
    .short_press_mask_o  (short_press_mask_o),
    .long_release_mask_o (long_release_mask_o),
    .long_press_mask_o   (long_press_mask_o),
    .repeat_mask_o       (repeat_mask_o),
    .report_mode_o       (report_mode_o)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // The receiver stalls at random with the probability of the current phase.
  // It is driven at the clock edge, so the block sees a stable level all cycle.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(1, 100) <= stall_pct);
  end

  // Watchdog: a hung handshake ends the run as a failure. The count starts at
  // zero with the simulation.
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Monitor. Both handshakes are sampled at the edge, before any driver update
  // of that edge lands, so each beat is seen exactly once with its own payload.
  // A report can never belong to a scan taken at the same edge, so the order of
  // the two checks below does not matter.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (in_valid_i && !in_stall_o) board.note_scan(touch_status_i);
      if (out_valid_o && !out_stall_i) begin
        board.check_report({pressed_mask_o, short_press_mask_o, long_release_mask_o,
                            long_press_mask_o, repeat_mask_o, report_mode_o});
      end
    end
  end

  // Present one scan and hold it until the block takes it. Valid is left high on
  // return; the caller either presents the next scan or lowers valid to idle.
  task automatic send_scan(input logic [STATUS_BITS-1:0] scan);
    in_valid_i <= 1'b1;
    touch_status_i <= scan;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Change the mode tag only with nothing in flight: stop sending, wait for the
  // last report, then give a scan that produces no report time to retire.
  task automatic write_mode(input logic [MODE_BITS-1:0] value);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_write_en_i <= 1'b1;
    cfg_write_data_i <= value;
    @(posedge clk_i);
    cfg_write_en_i <= 1'b0;
    board.set_mode(value);
  endtask

  // One random phase. Most scans follow a per-key hold model in which each key
  // flips level with a probability of 2, 8 or 30 percent, so at the low rates
  // keys are held long enough to reach long press, repeat and a saturated
  // history. The toggle rate changes every fifty scans, and about one scan in
  // twenty is pure noise. The unused upper status bits are always random.
  task automatic run_phase(input int idle_pct, input int stall_level);
    logic [STATUS_BITS-1:0] scan;
    int                     toggle_pct;
    stall_pct = stall_level;
    toggle_pct = 5;
    for (int n = 0; n < PHASE_SCANS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: begin
            toggle_pct = 2;
          end
          1: begin
            toggle_pct = 8;
          end
          default: begin
            toggle_pct = 30;
          end
        endcase
      end
      if ($urandom_range(1, 100) <= idle_pct) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while ($urandom_range(1, 100) <= idle_pct);
      end
      scan = STATUS_BITS'($urandom);
      if ($urandom_range(0, 19) != 0) begin
        for (int k = 0; k < KEY_COUNT; k++) begin
          if ($urandom_range(1, 100) <= toggle_pct) held_keys[k] = !held_keys[k];
        end
        scan[KEY_COUNT-1:0] = held_keys;
      end
      send_scan(scan);
    end
  endtask

  initial begin
    board = new();
    stall_pct = 0;
    held_keys = '0;
    rst_ni <= 1'b0;
    cfg_write_en_i <= 1'b0;
    cfg_write_data_i <= '0;
    in_valid_i <= 1'b0;
    touch_status_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, run with the mode tag still at its reset value.
    // An all-released scan and one with only the unused bits set report nothing.
    send_scan(12'h000);
    send_scan(12'hE00);
    // A single-scan touch on key 0 and its release give a short press.
    send_scan(12'h001);
    send_scan(12'h000);
    // All keys held: long press starts on the eighth scan, repeat on the ninth,
    // and past sixteen scans the history saturates and keeps flagging both.
    for (int n = 0; n < 18; n++) send_scan(12'h1FF);
    // Releasing them all, with the unused bits high, gives a long release.
    send_scan(12'hE00);
    // Every status bit high, then alternating patterns and a full release.
    send_scan(12'hFFF);
    send_scan(12'h155);
    send_scan(12'h0AA);
    send_scan(12'h000);

    // Random phases: no idling, sender idling, receiver stalling, both. The mode
    // tag goes through both extremes and a value in between; every write drains
    // the block first, which also gives a full pause of the sender.
    write_mode(4'hF);
    run_phase(0, 0);
    write_mode(4'h0);
    run_phase(82, 0);
    write_mode(MODE_BITS'($urandom_range(1, 14)));
    run_phase(0, 82);
    write_mode(4'hF);
    run_phase(35, 35);

    // Drain, then let the pipeline settle before the verdict.
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
